// ----- hdl/ietw_pkg.sv -----
// Shared widths, word codes and the binary-to-decimal step for the word token block.
`default_nettype none

package ietw_pkg;

   localparam int VALUE_W         = 31;
   localparam int CODE_W          = 5;
   localparam int DIGITS          = 10;
   localparam int BCD_W           = 4 * DIGITS;
   localparam int DAB_W           = BCD_W + VALUE_W;
   localparam int DAB_STAGES      = 4;
   localparam int STEPS_PER_STAGE = 8;
   localparam int GROUPS          = 4;
   localparam int SLOTS_PER_GROUP = 5;
   localparam int SLOTS           = GROUPS * SLOTS_PER_GROUP;

   localparam logic [CODE_W-1:0] CODE_ZERO      = 5'd0;
   localparam logic [CODE_W-1:0] CODE_TEN       = 5'd10;
   localparam logic [CODE_W-1:0] CODE_TENS_BASE = 5'd18;
   localparam logic [CODE_W-1:0] CODE_HUNDRED   = 5'd28;
   localparam logic [CODE_W-1:0] CODE_THOUSAND  = 5'd29;
   localparam logic [CODE_W-1:0] CODE_MILLION   = 5'd30;
   localparam logic [CODE_W-1:0] CODE_BILLION   = 5'd31;

   typedef logic [VALUE_W-1:0]            value_type;
   typedef logic [CODE_W-1:0]             code_type;
   typedef logic [DAB_W-1:0]              dab_type;
   typedef logic [SLOTS-1:0]              slot_mask_type;
   typedef logic [SLOTS-1:0][CODE_W-1:0]  slot_code_type;

   // One shift-and-add-three step: decimal digits above, remaining binary bits below.
   function automatic dab_type dab_step(input dab_type x);
      dab_type y;
      y = x;
      for (int d = 0; d < DIGITS; d++) begin
         if (y[VALUE_W + 4*d +: 4] >= 4'd5) begin
            y[VALUE_W + 4*d +: 4] = y[VALUE_W + 4*d +: 4] + 4'd3;
         end
      end
      return y << 1;
   endfunction

   // Up to eight chained steps; the last stage runs fewer.
   function automatic dab_type dab_steps(input dab_type x, input int unsigned n);
      dab_type y;
      y = x;
      for (int i = 0; i < STEPS_PER_STAGE; i++) begin
         if (i < n) begin
            y = dab_step(y);
         end
      end
      return y;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/ietw_req_if.sv -----
// Input channel: one integer value per beat.
`default_nettype none

interface ietw_req_if;
   import ietw_pkg::*;

   logic      valid;
   logic      ready;
   value_type value;

   modport source (output valid, output value, input ready);
   modport sink (input valid, input value, output ready);
endinterface

`default_nettype wire

// ----- hdl/ietw_rsp_if.sv -----
// Result channel: one word token per beat, last token flagged.
`default_nettype none

interface ietw_rsp_if;
   import ietw_pkg::*;

   logic     valid;
   logic     ready;
   code_type word_code;
   logic     last_word;

   modport source (output valid, output word_code, output last_word, input ready);
   modport sink (input valid, input word_code, input last_word, output ready);
endinterface

`default_nettype wire

// ----- hdl/integer_to_english_word_tokens.sv -----
// Top level: spells a 31-bit integer as a run of English word tokens.
`default_nettype none

// A value enters on every beat that the pipeline can take. Four register stages convert it
// to ten decimal digits (eight shift-and-add-three steps each, seven in the last), a fifth
// lays out the words of the billion, million, thousand and unit groups as a slot mask, and
// an emitter then sends one token per cycle, unless the output is stalled, from the lowest
// set slot through an output register. A value has 1 to 16 tokens for 31-bit inputs; the
// emitter's one-token-per-cycle output is what sets the sustained rate. The emitter takes
// the next value in the cycle it sends the previous value's last token, so back-to-back
// values leave no gap. Values pass through the conversion, slot, emitter and output registers.
module integer_to_english_word_tokens
   import ietw_pkg::*;
(
   input wire logic   clock,
   input wire logic   reset,
   ietw_req_if.sink   req_bus,
   ietw_rsp_if.source rsp_bus
);

   dab_type       dab_ff       [DAB_STAGES];
   dab_type       dab_in       [DAB_STAGES];
   logic          dab_valid_ff [DAB_STAGES];
   logic          dab_valid_in [DAB_STAGES];
   logic          stage_ready  [DAB_STAGES+1];

   logic          tok_valid_ff, tok_valid_in;
   slot_mask_type tok_mask_ff, tok_mask_in;
   slot_code_type tok_code_ff, tok_code_in;

   slot_mask_type emit_mask_ff, emit_mask_in;
   slot_code_type emit_code_ff, emit_code_in;

   logic          rsp_valid_ff, rsp_valid_in;
   code_type      rsp_code_ff, rsp_code_in;
   logic          rsp_last_ff, rsp_last_in;

   slot_mask_type pick_sel;
   slot_mask_type remaining;
   code_type      pick_code;
   logic          out_take;
   logic          pop;
   logic          load_en;

   // Pipeline handshake.
   always_comb begin
      stage_ready[DAB_STAGES] = !tok_valid_ff || load_en;
      for (int k = DAB_STAGES - 1; k >= 0; k--) begin
         stage_ready[k] = !dab_valid_ff[k] || stage_ready[k+1];
      end
   end

   assign req_bus.ready = stage_ready[0];

   // Binary to decimal stages.
   always_comb begin
      for (int k = 0; k < DAB_STAGES; k++) begin
         dab_in[k]       = dab_ff[k];
         dab_valid_in[k] = dab_valid_ff[k];
         if (stage_ready[k]) begin
            if (k == 0) begin
               dab_valid_in[k] = req_bus.valid;
               dab_in[k] = dab_steps({{BCD_W{1'b0}}, req_bus.value}, STEPS_PER_STAGE);
            end else begin
               dab_valid_in[k] = dab_valid_ff[k-1];
               dab_in[k] = dab_steps(dab_ff[k-1],
                  ((VALUE_W - STEPS_PER_STAGE * k) < STEPS_PER_STAGE) ?
                  (VALUE_W - STEPS_PER_STAGE * k) : STEPS_PER_STAGE);
            end
         end
      end
   end

   // Word slot layout: per group hundreds digit, Hundred, tens or teen, ones, scale.
   always_comb begin
      logic [BCD_W-1:0] bcd;
      logic [3:0]       h, t, o;
      int               base;
      logic             nz;
      bcd         = dab_ff[DAB_STAGES-1][DAB_W-1:VALUE_W];
      tok_mask_in = '0;
      tok_code_in = '0;
      for (int g = 0; g < GROUPS; g++) begin
         base = g * SLOTS_PER_GROUP;
         if (g == 0) begin
            h = 4'd0;
            t = 4'd0;
            o = bcd[4*9 +: 4];
         end else begin
            h = bcd[4*(3*(GROUPS-1-g)+2) +: 4];
            t = bcd[4*(3*(GROUPS-1-g)+1) +: 4];
            o = bcd[4*(3*(GROUPS-1-g))   +: 4];
         end
         nz = (h != 4'd0) || (t != 4'd0) || (o != 4'd0);
         tok_mask_in[base]   = (h != 4'd0);
         tok_code_in[base]   = {1'b0, h};
         tok_mask_in[base+1] = (h != 4'd0);
         tok_code_in[base+1] = CODE_HUNDRED;
         if (t < 4'd2) begin
            tok_mask_in[base+2] = (t != 4'd0) || (o != 4'd0);
            tok_code_in[base+2] = t[0] ? (CODE_TEN + {1'b0, o}) : {1'b0, o};
         end else begin
            tok_mask_in[base+2] = 1'b1;
            tok_code_in[base+2] = CODE_TENS_BASE + {1'b0, t};
            tok_mask_in[base+3] = (o != 4'd0);
            tok_code_in[base+3] = {1'b0, o};
         end
         tok_mask_in[base+4] = nz && (g != GROUPS - 1);
         case (g)
            0:       tok_code_in[base+4] = CODE_BILLION;
            1:       tok_code_in[base+4] = CODE_MILLION;
            default: tok_code_in[base+4] = CODE_THOUSAND;
         endcase
      end
      if (bcd == '0) begin
         tok_mask_in[(GROUPS-1)*SLOTS_PER_GROUP + 2] = 1'b1;
         tok_code_in[(GROUPS-1)*SLOTS_PER_GROUP + 2] = CODE_ZERO;
      end
      tok_valid_in = tok_valid_ff;
      if (stage_ready[DAB_STAGES]) begin
         tok_valid_in = dab_valid_ff[DAB_STAGES-1];
      end
   end

   // Emitter: lowest set slot goes out each cycle the output register can take it.
   always_comb begin
      logic found;
      found     = 1'b0;
      pick_sel  = '0;
      pick_code = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (emit_mask_ff[i] && !found) begin
            pick_sel[i] = 1'b1;
            found       = 1'b1;
         end
      end
      for (int i = 0; i < SLOTS; i++) begin
         if (pick_sel[i]) begin
            pick_code = pick_code | emit_code_ff[i];
         end
      end
   end

   assign remaining = emit_mask_ff & ~pick_sel;
   assign out_take  = !rsp_valid_ff || rsp_bus.ready;
   assign pop       = (emit_mask_ff != '0) && out_take;
   assign load_en   = tok_valid_ff && ((emit_mask_ff == '0) || (pop && (remaining == '0)));

   always_comb begin
      emit_mask_in = emit_mask_ff;
      emit_code_in = emit_code_ff;
      if (load_en) begin
         emit_mask_in = tok_mask_ff;
         emit_code_in = tok_code_ff;
      end else if (pop) begin
         emit_mask_in = remaining;
      end
      rsp_valid_in = rsp_valid_ff;
      rsp_code_in  = rsp_code_ff;
      rsp_last_in  = rsp_last_ff;
      if (out_take) begin
         rsp_valid_in = pop;
         rsp_code_in  = pick_code;
         rsp_last_in  = (remaining == '0);
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < DAB_STAGES; k++) begin
         dab_ff[k] <= dab_in[k];
      end
      tok_mask_ff  <= stage_ready[DAB_STAGES] ? tok_mask_in : tok_mask_ff;
      tok_code_ff  <= stage_ready[DAB_STAGES] ? tok_code_in : tok_code_ff;
      emit_code_ff <= emit_code_in;
      rsp_code_ff  <= rsp_code_in;
      rsp_last_ff  <= rsp_last_in;
      if (reset) begin
         for (int k = 0; k < DAB_STAGES; k++) begin
            dab_valid_ff[k] <= 1'b0;
         end
         tok_valid_ff <= 1'b0;
         emit_mask_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         for (int k = 0; k < DAB_STAGES; k++) begin
            dab_valid_ff[k] <= dab_valid_in[k];
         end
         tok_valid_ff <= tok_valid_in;
         emit_mask_ff <= emit_mask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.word_code = rsp_code_ff;
   assign rsp_bus.last_word = rsp_last_ff;

   // A value in the slot stage always has at least one word.
   a_tok_nonempty: assert property (@(posedge clock) disable iff (reset)
      tok_valid_ff |-> (tok_mask_ff != '0))
      else $error("slot stage holds a value with no words");

   // The billions digit of a 31-bit value never exceeds two.
   a_top_digit: assert property (@(posedge clock) disable iff (reset)
      dab_valid_ff[DAB_STAGES-1] |-> (dab_ff[DAB_STAGES-1][DAB_W-1 -: 4] <= 4'd2))
      else $error("decimal conversion produced a billions digit above two");

   // A stalled first stage keeps its value.
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      (dab_valid_ff[0] && !stage_ready[1]) |=> (dab_valid_ff[0] && $stable(dab_ff[0])))
      else $error("stalled conversion stage lost its value");

   // A popped token always lands in the output register.
   a_pop_lands: assert property (@(posedge clock) disable iff (reset)
      pop |=> (rsp_valid_ff && (rsp_last_ff == $past(remaining == '0))))
      else $error("emitted token missing from output register");

endmodule

`default_nettype wire
